/* sv/tdv_pkg.sv */
// ----------------------------------------------------------------------------
// tdv_pkg
// Shared types and constants for the telemetry datagram validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tdv_pkg;

  // record framing
  localparam logic [15:0] MAGIC_WORD     = 16'hF14E;
  localparam logic [7:0]  TYPE_TELEMETRY = 8'd1;
  localparam logic [5:0]  REC_LEN        = 6'd32;
  localparam logic [5:0]  COUNT_CAP      = 6'd33;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // verdict codes
  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_BAD_LEN   = 3'd1,
    VERDICT_BAD_MAGIC = 3'd2,
    VERDICT_NONFINITE = 3'd3,
    VERDICT_STALE     = 3'd4
  } verdict_t;

  // one classified datagram waiting for the sequence check
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] range_bits;
    logic [31:0] altitude_bits;
    logic [7:0]  mission_phase;
    logic [15:0] sequence_number;
    logic [31:0] sender_address;
  } q_entry_t;

  // queue handshake status: full gates input acceptance, valid is seen by the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

`default_nettype wire

/* sv/tdv_front.sv */
// ----------------------------------------------------------------------------
// tdv_front
// Collects datagram bytes into record fields and classifies length, magic,
// type and float exponents on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tdv_front
  import tdv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     byte_en,       // accepted byte transfer
  input  wire logic     byte_last,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] sender_address,
  output q_entry_t      entry,
  output logic          push
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [4:0]  idx;
  logic [15:0] magic_r;
  logic [7:0]  type_r;
  logic [7:0]  phase_r;
  logic [15:0] seq_r;
  logic [31:0] x_r, y_r, rg_r, alt_r;
  logic        len_ok, hdr_ok, finite_ok;

  assign idx = cnt_r[4:0];

  // byte counter, saturating, cleared after the final byte
  always_comb begin
    cnt_nxt = cnt_r;
    if (byte_en) begin
      if (byte_last) begin
        cnt_nxt = '0;
      end else if (cnt_r < COUNT_CAP) begin
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // byte lanes of the record, written at the current offset
  always_ff @(posedge clk) begin
    if (byte_en && cnt_r < REC_LEN) begin
      case (idx)
        5'd0: magic_r[7:0]  <= data_byte;
        5'd1: magic_r[15:8] <= data_byte;
        5'd2: type_r        <= data_byte;
        5'd3: phase_r       <= data_byte;
        5'd4: seq_r[7:0]    <= data_byte;
        5'd5: seq_r[15:8]   <= data_byte;
        default: begin
          case (idx[4:2])
            3'd3: x_r[{idx[1:0], 3'b000} +: 8]   <= data_byte;
            3'd4: y_r[{idx[1:0], 3'b000} +: 8]   <= data_byte;
            3'd5: rg_r[{idx[1:0], 3'b000} +: 8]  <= data_byte;
            3'd6: alt_r[{idx[1:0], 3'b000} +: 8] <= data_byte;
            default: ;
          endcase
        end
      endcase
    end
  end

  // checks on the final byte; the final byte of a full record is reserved
  assign len_ok    = (cnt_r == REC_LEN - 6'd1);
  assign hdr_ok    = (magic_r == MAGIC_WORD) && (type_r == TYPE_TELEMETRY);
  assign finite_ok = (x_r[30:23] != 8'hFF) && (y_r[30:23] != 8'hFF) &&
                     (rg_r[30:23] != 8'hFF) && (alt_r[30:23] != 8'hFF);

  always_comb begin
    if (!len_ok) begin
      entry.verdict = VERDICT_BAD_LEN;
    end else if (!hdr_ok) begin
      entry.verdict = VERDICT_BAD_MAGIC;
    end else if (!finite_ok) begin
      entry.verdict = VERDICT_NONFINITE;
    end else begin
      entry.verdict = VERDICT_ACCEPT;
    end
    entry.x_bits          = x_r;
    entry.y_bits          = y_r;
    entry.range_bits      = rg_r;
    entry.altitude_bits   = alt_r;
    entry.mission_phase   = phase_r;
    entry.sequence_number = seq_r;
    entry.sender_address  = sender_address;
  end

  assign push = byte_en && byte_last;

endmodule

`default_nettype wire

/* sv/tdv_queue.sv */
// ----------------------------------------------------------------------------
// tdv_queue
// Short queue of classified datagrams between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tdv_queue
  import tdv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  q_entry_t  wr_entry,
  input  wire logic pop,
  output q_entry_t  rd_entry,
  output q_status_t status
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign status.valid = (cnt_r != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign rd_entry     = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/tdv_back.sv */
// ----------------------------------------------------------------------------
// tdv_back
// Sequence freshness check, peer learning and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdv_back
  import tdv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  q_entry_t    entry,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        res_valid,
  input  wire logic   res_ready,
  output verdict_t    res_verdict,
  output logic [31:0] res_x_bits,
  output logic [31:0] res_y_bits,
  output logic [31:0] res_range_bits,
  output logic [31:0] res_altitude_bits,
  output logic [7:0]  res_mission_phase,
  output logic [15:0] res_sequence_number,
  output logic [31:0] res_peer_address,
  output logic        res_peer_known
);

  logic [15:0] last_seq_r;
  logic        seq_valid_r;
  logic [31:0] peer_r;
  logic        peer_valid_r;
  logic        out_valid_r;
  logic [15:0] diff;
  logic        stale;
  logic        accept;
  verdict_t    verdict;

  // freshness by signed 16-bit difference
  assign diff   = entry.sequence_number - last_seq_r;
  assign stale  = seq_valid_r && ((diff == 16'd0) || diff[15]);
  assign accept = (entry.verdict == VERDICT_ACCEPT) && !stale;

  always_comb begin
    if (entry.verdict != VERDICT_ACCEPT) begin
      verdict = entry.verdict;
    end else if (stale) begin
      verdict = VERDICT_STALE;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  assign pop = q_status.valid && (!out_valid_r || res_ready);

  // sequence and peer state, updated on accepted records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r   <= '0;
      seq_valid_r  <= 1'b0;
      peer_r       <= '0;
      peer_valid_r <= 1'b0;
    end else if (pop && accept) begin
      last_seq_r   <= entry.sequence_number;
      seq_valid_r  <= 1'b1;
      peer_r       <= entry.sender_address;
      peer_valid_r <= 1'b1;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, zero unless accepted; peer address and peer_known keep the learned peer
  always_ff @(posedge clk) begin
    if (pop) begin
      res_verdict         <= verdict;
      res_x_bits          <= accept ? entry.x_bits : '0;
      res_y_bits          <= accept ? entry.y_bits : '0;
      res_range_bits      <= accept ? entry.range_bits : '0;
      res_altitude_bits   <= accept ? entry.altitude_bits : '0;
      res_mission_phase   <= accept ? entry.mission_phase : '0;
      res_sequence_number <= accept ? entry.sequence_number : '0;
      res_peer_address    <= accept ? entry.sender_address : peer_r;
      res_peer_known      <= accept || peer_valid_r;
    end
  end

  assign res_valid = out_valid_r;

endmodule

`default_nettype wire

/* sv/telemetry_datagram_validator_core.sv */
// ----------------------------------------------------------------------------
// telemetry_datagram_validator_core
// Byte-stream telemetry record validator with length, header, float and
// sequence checks, and sender address learning.
// ----------------------------------------------------------------------------
// throughput: one byte transfer per cycle while in_tready is high, including final bytes
// path: a final byte's verdict is written into the queue with its transfer, then into
// the result register when the back pops it; out_tvalid is driven by that register
// stalls: in_tready drops while two verdicts wait behind a held result
// reset: synchronous rst_n clears byte count, queue, sequence and peer state
`default_nettype none

module telemetry_datagram_validator_core
  import tdv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // [7:0] data_byte, [39:8] sender_address
  input  wire logic         in_tlast,   // end_of_datagram
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] x_bits, [63:32] y_bits, [95:64] range_bits, [127:96] altitude_bits,
  // [135:128] mission_phase, [151:136] sequence_number, [183:152] peer_address
  output logic [183:0]      out_tdata,
  output logic [3:0]        out_tuser   // [2:0] verdict, [3] peer_known
);

  q_entry_t  f_entry, q_entry;
  q_status_t q_status;
  logic      f_push, b_pop, byte_en;
  verdict_t  res_verdict;

  assign in_tready = !q_status.full;
  assign byte_en   = in_tvalid && in_tready;

  // front: byte collection and classification
  tdv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (byte_en),
    .byte_last      (in_tlast),
    .data_byte      (in_tdata[7:0]),
    .sender_address (in_tdata[39:8]),
    .entry          (f_entry),
    .push           (f_push)
  );

  // queue between front and back
  tdv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_entry (f_entry),
    .pop      (b_pop),
    .rd_entry (q_entry),
    .status   (q_status)
  );

  // back: sequence check and result register
  tdv_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .entry               (q_entry),
    .q_status            (q_status),
    .pop                 (b_pop),
    .res_valid           (out_tvalid),
    .res_ready           (out_tready),
    .res_verdict         (res_verdict),
    .res_x_bits          (out_tdata[31:0]),
    .res_y_bits          (out_tdata[63:32]),
    .res_range_bits      (out_tdata[95:64]),
    .res_altitude_bits   (out_tdata[127:96]),
    .res_mission_phase   (out_tdata[135:128]),
    .res_sequence_number (out_tdata[151:136]),
    .res_peer_address    (out_tdata[183:152]),
    .res_peer_known      (out_tuser[3])
  );

  assign out_tuser[2:0] = res_verdict;

endmodule

`default_nettype wire
